// File: rtl/spp_pkg.sv
// Shared constants and types for the stable pivot partition block.
package spp_pkg;

  localparam int SPP_DEPTH = 32;
  localparam int SPP_W     = 32;

  typedef logic signed [SPP_W-1:0] spp_word_t;

  typedef struct packed {
    logic shift;
    logic load;
  } spp_cell_ctl_t;

endpackage

// File: rtl/spp_cell.sv
// One storage cell of the order-keeping chain: loads a new value or takes its neighbor's.
module spp_cell (
  input  logic                   clk,
  input  spp_pkg::spp_cell_ctl_t ctl,
  input  spp_pkg::spp_word_t     din_new,
  input  spp_pkg::spp_word_t     din_nb,
  output spp_pkg::spp_word_t     q
);
  import spp_pkg::*;

  spp_word_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q_r <= din_nb;
    end else if (ctl.load) begin
      q_r <= din_new;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/stable_pivot_partition.sv
// Top level: stable partition of a value stream around a configurable pivot.
//
// Input channel (in_valid/in_ready) carries one signed value per beat, with
// in_last marking the end of a sequence. Values below the pivot leave on the
// output channel (out_valid/out_ready) in the cycle after their beat. Other
// values enter a chain of BUFFER_DEPTH cells, each filled at the first free
// slot and shifted one step toward the head per unstalled drain cycle. After
// the last beat the chain drains head first, one value per unstalled cycle,
// while in_ready is low; the final value carries out_last. A full chain drops
// the value and sets a sticky out_overflow, cleared when the sequence ends.
// Throughput: one beat per cycle outside a drain while the output is free;
// a drain moves each held value out through the single shift step of the chain.
// A single output register holds the current result; while it is stalled,
// input and draining pause. cfg_we writes the pivot (reset value 0).
// Synchronous reset empties the chain, clears the sticky drop state and the output valid.
module stable_pivot_partition #(
  parameter int BUFFER_DEPTH = spp_pkg::SPP_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  spp_pkg::spp_word_t cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  spp_pkg::spp_word_t in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output spp_pkg::spp_word_t out_value,
  output logic               out_last,
  output logic               out_overflow
);
  import spp_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt, cnt_after;
  logic            drop_r, drop_nxt, drop_after;
  spp_word_t       pivot_r;
  logic            out_valid_r, out_valid_nxt;
  spp_word_t       out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            accept, out_free, below, full, push, drop_now, shift;
  spp_word_t       cell_q [BUFFER_DEPTH];
  spp_cell_ctl_t   cell_ctl [BUFFER_DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < BUFFER_DEPTH; gi++) begin : g_cell
      spp_word_t nb;
      if (gi == BUFFER_DEPTH - 1) begin : g_tail
        assign nb = cell_q[gi];
      end else begin : g_mid
        assign nb = cell_q[gi+1];
      end
      assign cell_ctl[gi].shift = shift;
      assign cell_ctl[gi].load  = push && (count_r == CW'(gi));
      spp_cell u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[gi]),
        .din_new (in_value),
        .din_nb  (nb),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign below     = in_value < pivot_r;
  assign full      = count_r == CW'(BUFFER_DEPTH);
  assign push      = accept && !below && !full;
  assign drop_now  = accept && !below && full;
  assign cnt_after = push ? count_r + CW'(1) : count_r;
  assign drop_after = drop_r | drop_now;
  assign shift     = (state_r == ST_DRAIN) && out_free;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = cnt_after;
          drop_nxt  = drop_after;
          if (below) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = in_value;
            out_last_nxt  = in_last && (cnt_after == '0);
            out_ovf_nxt   = drop_after;
          end
          if (in_last) begin
            if (cnt_after == '0) begin
              drop_nxt = 1'b0;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_q[0];
          out_last_nxt  = count_r == CW'(1);
          out_ovf_nxt   = drop_r;
          count_nxt     = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_IDLE;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pivot_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pivot_r <= cfg_wdata;
      end
    end
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUFFER_DEPTH))
    else $error("held count above buffer depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("drain with empty chain");

  a_drop_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (full || (state_r == ST_DRAIN)))
    else $error("overflow flag set while chain not full");

  a_drain_pop: assert property (@(posedge clk) disable iff (!rst_n)
    shift |=> out_valid_r && (count_r == $past(count_r) - CW'(1)))
    else $error("drain step lost a value");

endmodule
